/* sv/srl_pkg.sv */
package srl_pkg;

	typedef enum logic [3:0] {
		PH_START    = 4'd0,
		PH_TYPE     = 4'd1,
		PH_SKIP     = 4'd2,
		PH_COUNT    = 4'd3,
		PH_ADDR_HI  = 4'd4,
		PH_ADDR_LO  = 4'd5,
		PH_DATA     = 4'd6,
		PH_CHECK    = 4'd7,
		PH_S9_COUNT = 4'd8,
		PH_S9_HI    = 4'd9,
		PH_S9_LO    = 4'd10
	} phase_t;

	localparam logic [1:0] KIND_WRITE = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_OK    = 2'd2;
	localparam logic [1:0] KIND_FAIL  = 2'd3;

	localparam logic [2:0] ERR_NOT_S    = 3'd0;
	localparam logic [2:0] ERR_TYPE     = 3'd1;
	localparam logic [2:0] ERR_CHECKSUM = 3'd2;
	localparam logic [2:0] ERR_OVERFLOW = 3'd3;
	localparam logic [2:0] ERR_HEX      = 3'd4;
	localparam logic [2:0] ERR_TRUNC    = 3'd5;

	localparam logic [7:0] CH_UPPER_S = 8'h53;
	localparam logic [7:0] CH_LOWER_S = 8'h73;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	localparam logic [7:0]  COUNT_OVERHEAD = 8'd3;
	localparam logic [7:0]  SUM_GOOD       = 8'hFF;
	localparam logic [16:0] ADDR_LIMIT     = 17'h0FFFF;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  bytes_left;
		logic [16:0] load_address;
		logic [7:0]  running_sum;
		logic [3:0]  high_nibble;
		logic        nibble_toggle;
		logic        stopped;
	} state_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [15:0] address;
		logic [7:0]  data_byte;
		logic [2:0]  error_code;
	} result_t;

	// Bit 4 flags a valid hex digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		begin
			r = '0;
			if (c inside {[CH_ZERO:CH_NINE]}) begin
				r = {1'b1, 4'(c - CH_ZERO)};
			end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
				r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
			end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
				r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
			end
			return r;
		end
	endfunction

endpackage

/* sv/srl_in_if.sv */
interface srl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink (input valid, input char_in, input end_of_input, output ready);
endinterface

/* sv/srl_out_if.sv */
interface srl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [15:0] address;
	logic [7:0]  data_byte;
	logic [2:0]  error_code;

	modport source (output valid, output result_kind, output address, output data_byte,
		output error_code, input ready);
	modport sink (input valid, input result_kind, input address, input data_byte,
		input error_code, output ready);
endinterface

/* sv/srl_step.sv */
module srl_step (
	input  srl_pkg::state_t  cur,
	input  logic [7:0]       char_in,
	input  logic             end_of_input,
	output srl_pkg::state_t  nxt,
	output logic             emit,
	output srl_pkg::result_t res
);

	logic [4:0] hex;
	logic [7:0] byte_val;
	logic [7:0] sum_b;
	logic       hex_phase;

	assign hex      = srl_pkg::hex_decode(char_in);
	assign byte_val = {cur.high_nibble, hex[3:0]};
	assign sum_b    = cur.running_sum + byte_val;
	assign hex_phase = cur.phase inside {[srl_pkg::PH_COUNT:srl_pkg::PH_S9_LO]};

	always_comb begin
		nxt  = cur;
		emit = 1'b0;
		res  = '0;
		if (cur.stopped) begin
			emit = 1'b0;
		end else if (end_of_input) begin
			nxt.stopped = 1'b1;
			emit = 1'b1;
			if (hex_phase || cur.phase == srl_pkg::PH_TYPE) begin
				res.result_kind = srl_pkg::KIND_FAIL;
				res.error_code  = srl_pkg::ERR_TRUNC;
			end else begin
				res.result_kind = srl_pkg::KIND_OK;
			end
		end else if (char_in == srl_pkg::CH_CR) begin
			emit = 1'b0;
		end else if (cur.phase == srl_pkg::PH_TYPE) begin
			case (char_in)
				srl_pkg::CH_ZERO: begin
					nxt.phase = srl_pkg::PH_SKIP;
				end
				srl_pkg::CH_ONE: begin
					nxt.running_sum   = '0;
					nxt.nibble_toggle = 1'b0;
					nxt.phase         = srl_pkg::PH_COUNT;
				end
				srl_pkg::CH_NINE: begin
					nxt.nibble_toggle = 1'b0;
					nxt.phase         = srl_pkg::PH_S9_COUNT;
				end
				default: begin
					nxt.stopped     = 1'b1;
					emit            = 1'b1;
					res.result_kind = srl_pkg::KIND_FAIL;
					res.error_code  = (char_in == srl_pkg::CH_LF) ? srl_pkg::ERR_TRUNC
						: srl_pkg::ERR_TYPE;
				end
			endcase
		end else if (cur.phase == srl_pkg::PH_SKIP) begin
			if (char_in == srl_pkg::CH_LF) begin
				nxt.phase = srl_pkg::PH_START;
			end
		end else if (!hex_phase) begin
			if (char_in inside {srl_pkg::CH_UPPER_S, srl_pkg::CH_LOWER_S}) begin
				nxt.phase = srl_pkg::PH_TYPE;
			end else begin
				nxt.phase       = srl_pkg::PH_START;
				nxt.stopped     = 1'b1;
				emit            = 1'b1;
				res.result_kind = srl_pkg::KIND_FAIL;
				res.error_code  = srl_pkg::ERR_NOT_S;
			end
		end else if (char_in == srl_pkg::CH_LF || !hex[4]) begin
			nxt.stopped     = 1'b1;
			emit            = 1'b1;
			res.result_kind = srl_pkg::KIND_FAIL;
			res.error_code  = (char_in == srl_pkg::CH_LF) ? srl_pkg::ERR_TRUNC
				: srl_pkg::ERR_HEX;
		end else if (!cur.nibble_toggle) begin
			nxt.high_nibble   = hex[3:0];
			nxt.nibble_toggle = 1'b1;
		end else begin
			nxt.nibble_toggle = 1'b0;
			case (cur.phase)
				srl_pkg::PH_COUNT: begin
					nxt.running_sum = sum_b;
					nxt.bytes_left  = (byte_val >= srl_pkg::COUNT_OVERHEAD)
						? byte_val - srl_pkg::COUNT_OVERHEAD : '0;
					nxt.phase       = srl_pkg::PH_ADDR_HI;
				end
				srl_pkg::PH_ADDR_HI: begin
					nxt.running_sum  = sum_b;
					nxt.load_address = {1'b0, byte_val, 8'h00};
					nxt.phase        = srl_pkg::PH_ADDR_LO;
				end
				srl_pkg::PH_ADDR_LO: begin
					nxt.running_sum       = sum_b;
					nxt.load_address[7:0] = cur.load_address[7:0] | byte_val;
					nxt.phase = (cur.bytes_left != '0) ? srl_pkg::PH_DATA : srl_pkg::PH_CHECK;
				end
				srl_pkg::PH_DATA: begin
					emit = 1'b1;
					if (cur.load_address > srl_pkg::ADDR_LIMIT) begin
						nxt.stopped     = 1'b1;
						res.result_kind = srl_pkg::KIND_FAIL;
						res.error_code  = srl_pkg::ERR_OVERFLOW;
					end else begin
						nxt.running_sum  = sum_b;
						nxt.load_address = cur.load_address + 17'd1;
						nxt.bytes_left   = cur.bytes_left - 8'd1;
						if (cur.bytes_left == 8'd1) begin
							nxt.phase = srl_pkg::PH_CHECK;
						end
						res.result_kind = srl_pkg::KIND_WRITE;
						res.address     = cur.load_address[15:0];
						res.data_byte   = byte_val;
					end
				end
				srl_pkg::PH_CHECK: begin
					nxt.running_sum = sum_b;
					if (sum_b != srl_pkg::SUM_GOOD) begin
						nxt.stopped     = 1'b1;
						emit            = 1'b1;
						res.result_kind = srl_pkg::KIND_FAIL;
						res.error_code  = srl_pkg::ERR_CHECKSUM;
					end else begin
						nxt.phase = srl_pkg::PH_SKIP;
					end
				end
				srl_pkg::PH_S9_COUNT: begin
					nxt.phase = srl_pkg::PH_S9_HI;
				end
				srl_pkg::PH_S9_HI: begin
					nxt.load_address = {1'b0, byte_val, 8'h00};
					nxt.phase        = srl_pkg::PH_S9_LO;
				end
				default: begin
					nxt.load_address[7:0] = cur.load_address[7:0] | byte_val;
					nxt.phase       = srl_pkg::PH_SKIP;
					emit            = 1'b1;
					res.result_kind = srl_pkg::KIND_START;
					res.address     = {cur.load_address[15:8],
						cur.load_address[7:0] | byte_val};
				end
			endcase
		end
	end

endmodule

/* sv/srecord_loader_parser.sv */
// S-record loader: takes one character per transfer and produces memory writes, the start
// address, and a final success or failure result. One character is accepted every clock
// cycle unless a result waits to be taken; each one is registered, then decoded against
// the parser state, and its result (if any) is held in an output register. The input side
// stalls only while a result waits to be taken. After a failure or end of input the parser
// accepts characters but reports nothing until reset.
module srecord_loader_parser (
	input  logic       clk,
	input  logic       arst_n,
	srl_in_if.sink     items,
	srl_out_if.source  results
);

	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eoi_s1;
	logic              out_valid_q;
	srl_pkg::result_t  res_q;
	srl_pkg::state_t   state_q;
	srl_pkg::state_t   state_nxt;
	srl_pkg::result_t  res_nxt;
	logic              emit;
	logic              advance;

	assign advance     = valid_s1 && (!out_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.valid && items.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			char_s1 <= items.char_in;
			eoi_s1  <= items.end_of_input;
		end
	end

	srl_step u_step (
		.cur          (state_q),
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.nxt          (state_nxt),
		.emit         (emit),
		.res          (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			state_q     <= state_nxt;
			out_valid_q <= emit;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.result_kind = res_q.result_kind;
	assign results.address     = res_q.address;
	assign results.data_byte   = res_q.data_byte;
	assign results.error_code  = res_q.error_code;

endmodule

/* test/srecord_loader_parser_test.sv */
module srecord_loader_parser_test;

	localparam int unsigned ITEM_TARGET = 1550;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic             eoi;
		logic [7:0]       ch;
		bit               typed;
		bit               gives;
		srl_pkg::result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	srl_in_if  char_bus ();
	srl_out_if result_bus ();

	srecord_loader_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (char_bus),
		.results (result_bus)
	);

	// Parser state as seen by the predictor.
	srl_pkg::phase_t parse_phase;
	logic [7:0]      pending_bytes;
	logic [16:0]     write_addr;
	logic [7:0]      byte_sum;
	logic [3:0]      upper_nibble;
	logic            nibble_held;
	logic            parser_halted;

	srl_pkg::result_t due_results [$];
	logic [7:0]       line_q [$];

	int unsigned parsed_items;
	int unsigned sent_chars;
	int unsigned errors;
	int unsigned writes_seen;
	int unsigned starts_seen;
	int unsigned cycle_count;
	int unsigned tx_idle_pct;
	int unsigned rx_stall_pct;
	int unsigned hold_left;
	bit          hold_req;
	bit          hold_taken;
	logic [1:0]  last_kind;
	logic [2:0]  last_code;

	// Two records and a skipped header line; every character is one transfer.
	stim_row_t opening [26] = '{
		'{1'b0, srl_pkg::CH_UPPER_S, 1'b1, 1'b0, '0},
		'{1'b0, srl_pkg::CH_ZERO,    1'b1, 1'b0, '0},
		'{1'b0, srl_pkg::CH_LF,      1'b1, 1'b0, '0},
		'{1'b0, srl_pkg::CH_UPPER_S, 1'b0, 1'b0, '0},
		'{1'b0, "1",        1'b0, 1'b0, '0},
		'{1'b0, "0",        1'b0, 1'b0, '0},
		'{1'b0, "4",        1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b0, 1'b0, '0},
		'{1'b0, srl_pkg::CH_CR,      1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b0, 1'b0, '0},
		'{1'b0, "A",        1'b0, 1'b0, '0},
		'{1'b0, "B",        1'b1, 1'b1, '{srl_pkg::KIND_WRITE, 16'hFFFF, 8'hAB, 3'd0}},
		'{1'b0, "5",        1'b0, 1'b0, '0},
		'{1'b0, "2",        1'b0, 1'b0, '0},
		'{1'b0, srl_pkg::CH_LF,      1'b0, 1'b0, '0},
		'{1'b0, srl_pkg::CH_LOWER_S, 1'b0, 1'b0, '0},
		'{1'b0, "9",        1'b0, 1'b0, '0},
		'{1'b0, "0",        1'b0, 1'b0, '0},
		'{1'b0, "3",        1'b0, 1'b0, '0},
		'{1'b0, "f",        1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b0, 1'b0, '0},
		'{1'b0, "f",        1'b0, 1'b0, '0},
		'{1'b0, "F",        1'b1, 1'b1, '{srl_pkg::KIND_START, 16'hFFFF, 8'h00, 3'd0}},
		'{1'b0, srl_pkg::CH_LF,      1'b0, 1'b0, '0}
	};

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int nibble_of(input logic [7:0] c);
		if (c inside {[srl_pkg::CH_ZERO:srl_pkg::CH_NINE]})
			return int'(c) - int'(srl_pkg::CH_ZERO);
		if (c inside {[srl_pkg::CH_UPPER_A:srl_pkg::CH_UPPER_F]})
			return int'(c) - int'(srl_pkg::CH_UPPER_A) + 10;
		if (c inside {[srl_pkg::CH_LOWER_A:srl_pkg::CH_LOWER_F]})
			return int'(c) - int'(srl_pkg::CH_LOWER_A) + 10;
		return -1;
	endfunction

	function automatic bit halt_with(input logic [2:0] code, output srl_pkg::result_t res);
		res = '0;
		res.result_kind = srl_pkg::KIND_FAIL;
		res.error_code = code;
		parser_halted = 1'b1;
		return 1'b1;
	endfunction

	function automatic bit decode_char(input logic eoi, input logic [7:0] ch,
		output srl_pkg::result_t res);
		int         dig;
		logic [7:0] value;
		res = '0;
		if (parser_halted) return 1'b0;
		if (eoi) begin
			parsed_items++;
			parser_halted = 1'b1;
			if (parse_phase inside {srl_pkg::PH_START, srl_pkg::PH_SKIP}) begin
				res.result_kind = srl_pkg::KIND_OK;
			end else begin
				res.result_kind = srl_pkg::KIND_FAIL;
				res.error_code = srl_pkg::ERR_TRUNC;
			end
			return 1'b1;
		end
		if (ch == srl_pkg::CH_CR) return 1'b0;
		if (parse_phase == srl_pkg::PH_SKIP) begin
			if (ch == srl_pkg::CH_LF) begin
				parse_phase = srl_pkg::PH_START;
				parsed_items++;
			end
			return 1'b0;
		end
		parsed_items++;
		if (parse_phase == srl_pkg::PH_TYPE) begin
			case (ch)
				srl_pkg::CH_ZERO: parse_phase = srl_pkg::PH_SKIP;
				srl_pkg::CH_ONE: begin
					byte_sum = '0;
					nibble_held = 1'b0;
					parse_phase = srl_pkg::PH_COUNT;
				end
				srl_pkg::CH_NINE: begin
					nibble_held = 1'b0;
					parse_phase = srl_pkg::PH_S9_COUNT;
				end
				srl_pkg::CH_LF: return halt_with(srl_pkg::ERR_TRUNC, res);
				default: return halt_with(srl_pkg::ERR_TYPE, res);
			endcase
			return 1'b0;
		end
		if (!(parse_phase inside {[srl_pkg::PH_COUNT:srl_pkg::PH_S9_LO]})) begin
			parse_phase = srl_pkg::PH_START;
			if (ch inside {srl_pkg::CH_UPPER_S, srl_pkg::CH_LOWER_S}) begin
				parse_phase = srl_pkg::PH_TYPE;
				return 1'b0;
			end
			return halt_with(srl_pkg::ERR_NOT_S, res);
		end
		if (ch == srl_pkg::CH_LF) return halt_with(srl_pkg::ERR_TRUNC, res);
		dig = nibble_of(ch);
		if (dig < 0) return halt_with(srl_pkg::ERR_HEX, res);
		if (!nibble_held) begin
			upper_nibble = 4'(dig);
			nibble_held = 1'b1;
			return 1'b0;
		end
		nibble_held = 1'b0;
		value = {upper_nibble, 4'(dig)};
		case (parse_phase)
			srl_pkg::PH_COUNT: begin
				byte_sum += value;
				pending_bytes = (value >= srl_pkg::COUNT_OVERHEAD)
					? value - srl_pkg::COUNT_OVERHEAD : 8'd0;
				parse_phase = srl_pkg::PH_ADDR_HI;
			end
			srl_pkg::PH_ADDR_HI: begin
				byte_sum += value;
				write_addr = {1'b0, value, 8'h00};
				parse_phase = srl_pkg::PH_ADDR_LO;
			end
			srl_pkg::PH_ADDR_LO: begin
				byte_sum += value;
				write_addr[7:0] = value;
				parse_phase = (pending_bytes != 0) ? srl_pkg::PH_DATA : srl_pkg::PH_CHECK;
			end
			srl_pkg::PH_DATA: begin
				if (write_addr > srl_pkg::ADDR_LIMIT) return halt_with(srl_pkg::ERR_OVERFLOW, res);
				byte_sum += value;
				res.result_kind = srl_pkg::KIND_WRITE;
				res.address = write_addr[15:0];
				res.data_byte = value;
				write_addr = write_addr + 17'd1;
				pending_bytes = pending_bytes - 8'd1;
				if (pending_bytes == 0) parse_phase = srl_pkg::PH_CHECK;
				return 1'b1;
			end
			srl_pkg::PH_CHECK: begin
				byte_sum += value;
				if (byte_sum != srl_pkg::SUM_GOOD) return halt_with(srl_pkg::ERR_CHECKSUM, res);
				parse_phase = srl_pkg::PH_SKIP;
			end
			srl_pkg::PH_S9_COUNT: parse_phase = srl_pkg::PH_S9_HI;
			srl_pkg::PH_S9_HI: begin
				write_addr = {1'b0, value, 8'h00};
				parse_phase = srl_pkg::PH_S9_LO;
			end
			default: begin
				write_addr[7:0] = value;
				parse_phase = srl_pkg::PH_SKIP;
				res.result_kind = srl_pkg::KIND_START;
				res.address = write_addr[15:0];
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return srl_pkg::CH_ZERO + 8'(n);
		return ($urandom_range(1) ? srl_pkg::CH_UPPER_A : srl_pkg::CH_LOWER_A) + 8'(n - 4'd10);
	endfunction

	// Carriage returns may fall anywhere, including between the digits of a pair.
	function automatic void put_char(input logic [7:0] c);
		if ($urandom_range(99) < 4) line_q.push_back(srl_pkg::CH_CR);
		line_q.push_back(c);
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		put_char(hex_char(b[7:4]));
		put_char(hex_char(b[3:0]));
	endfunction

	function automatic void put_tail();
		int unsigned n;
		logic [7:0]  c;
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : 0;
		repeat (n) begin
			c = 8'($urandom_range(255));
			if (c == srl_pkg::CH_LF) c = srl_pkg::CH_CR;
			line_q.push_back(c);
		end
		put_char(srl_pkg::CH_LF);
	endfunction

	function automatic void build_record();
		int unsigned pick;
		int unsigned cnt;
		int unsigned n;
		int unsigned base;
		logic [7:0]  sum;
		logic [7:0]  d;
		line_q.delete();
		pick = $urandom_range(99);
		put_char($urandom_range(1) ? srl_pkg::CH_UPPER_S : srl_pkg::CH_LOWER_S);
		if (pick < 15) begin
			put_char(srl_pkg::CH_ZERO);
			put_tail();
		end else if (pick < 30) begin
			put_char(srl_pkg::CH_NINE);
			put_byte(8'($urandom));
			put_byte(8'($urandom));
			put_byte(8'($urandom));
			put_tail();
		end else begin
			put_char(srl_pkg::CH_ONE);
			pick = $urandom_range(99);
			if (pick < 6) cnt = $urandom_range(0, 2);
			else if (pick < 9) cnt = $urandom_range(3, 255);
			else cnt = $urandom_range(3, 12);
			n = (cnt >= 3) ? cnt - 3 : 0;
			base = ($urandom_range(9) == 0) ? 32'hFFFF - $urandom_range(15)
				: $urandom_range(16'hFFFF);
			if (n != 0 && base + n > 32'h10000) base = 32'h10000 - n;
			sum = 8'(cnt) + 8'(base >> 8) + 8'(base);
			put_byte(8'(cnt));
			put_byte(8'(base >> 8));
			put_byte(8'(base));
			repeat (n) begin
				d = 8'($urandom);
				sum += d;
				put_byte(d);
			end
			put_byte(srl_pkg::SUM_GOOD - sum);
			put_tail();
		end
	endfunction

	// The parser stops for good after its first failure or end of input, so one
	// terminating case, picked at random, closes each run.
	function automatic bit build_ending();
		logic [7:0]  c;
		logic [7:0]  sum;
		logic [15:0] a;
		line_q.delete();
		case ($urandom_range(8))
			0: return 1'b1;
			1: begin
				put_char(srl_pkg::CH_UPPER_S);
				put_char(srl_pkg::CH_ZERO);
				line_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
				return 1'b1;
			end
			2: begin
				put_char(srl_pkg::CH_UPPER_S);
				if ($urandom_range(1)) begin
					put_char(srl_pkg::CH_ONE);
					put_char(hex_char(4'($urandom)));
				end
				return 1'b1;
			end
			3: begin
				do c = 8'($urandom_range(255));
				while (c inside {srl_pkg::CH_UPPER_S, srl_pkg::CH_LOWER_S, srl_pkg::CH_CR});
				line_q.push_back(c);
			end
			4: begin
				put_char(srl_pkg::CH_LOWER_S);
				do c = 8'($urandom_range(255));
				while (c inside {srl_pkg::CH_ZERO, srl_pkg::CH_ONE, srl_pkg::CH_NINE,
					srl_pkg::CH_CR});
				line_q.push_back(c);
			end
			5: begin
				a = 16'($urandom);
				sum = srl_pkg::COUNT_OVERHEAD + a[15:8] + a[7:0];
				put_char(srl_pkg::CH_UPPER_S);
				put_char(srl_pkg::CH_ONE);
				put_byte(srl_pkg::COUNT_OVERHEAD);
				put_byte(a[15:8]);
				put_byte(a[7:0]);
				put_byte(srl_pkg::SUM_GOOD - sum + 8'($urandom_range(1, 255)));
				put_char(srl_pkg::CH_LF);
			end
			6: begin
				put_char(srl_pkg::CH_UPPER_S);
				put_char(srl_pkg::CH_ONE);
				put_byte(8'h05);
				put_byte(8'hFF);
				put_byte(8'hFF);
				put_byte(8'($urandom));
				put_byte(8'($urandom));
				put_byte(8'($urandom));
				put_char(srl_pkg::CH_LF);
			end
			7: begin
				put_char(srl_pkg::CH_UPPER_S);
				put_char($urandom_range(1) ? srl_pkg::CH_ONE : srl_pkg::CH_NINE);
				do c = 8'($urandom_range(255));
				while (nibble_of(c) >= 0 || c == srl_pkg::CH_CR || c == srl_pkg::CH_LF);
				line_q.push_back(c);
			end
			default: begin
				put_char(srl_pkg::CH_UPPER_S);
				put_char(srl_pkg::CH_ONE);
				put_byte(8'h08);
				repeat ($urandom_range(3)) put_byte(8'($urandom));
				if ($urandom_range(1)) put_char(hex_char(4'($urandom)));
				line_q.push_back(srl_pkg::CH_LF);
			end
		endcase
		return 1'b0;
	endfunction

	function automatic void set_idling(input int unsigned mode);
		case (mode)
			0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
			1: begin tx_idle_pct = 55; rx_stall_pct = 0;  end
			2: begin tx_idle_pct = 0;  rx_stall_pct = 55; end
			default: begin tx_idle_pct = 22; rx_stall_pct = 22; end
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic send_item(input logic eoi, input logic [7:0] ch, input bit typed,
		input bit typed_gives, input srl_pkg::result_t typed_res);
		srl_pkg::result_t got;
		bit               gives;
		while ($urandom_range(99) < tx_idle_pct) begin
			char_bus.valid <= 1'b0;
			@(negedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.char_in <= ch;
		char_bus.end_of_input <= eoi;
		do @(posedge clk); while (!char_bus.ready);
		sent_chars++;
		gives = decode_char(eoi, ch, got);
		if (typed) begin
			gives = typed_gives;
			got = typed_res;
		end
		if (gives) due_results.push_back(got);
		@(negedge clk);
	endtask

	task automatic send_line();
		foreach (line_q[i]) send_item(1'b0, line_q[i], 1'b0, 1'b0, '0);
	endtask

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_left = HOLD_CYCLES;
			hold_taken = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_bus.ready <= 1'b0;
		end else begin
			result_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			last_kind = result_bus.result_kind;
			last_code = result_bus.error_code;
			if (result_bus.result_kind == srl_pkg::KIND_WRITE) writes_seen++;
			if (result_bus.result_kind == srl_pkg::KIND_START) starts_seen++;
			if (due_results.size() == 0) begin
				$error("result transfer with none expected: kind %0d address %0h",
					result_bus.result_kind, result_bus.address);
				errors++;
			end else begin
				check_field("result_kind", 16'(due_results[0].result_kind),
					16'(result_bus.result_kind));
				check_field("address", due_results[0].address, result_bus.address);
				check_field("data_byte", 16'(due_results[0].data_byte),
					16'(result_bus.data_byte));
				check_field("error_code", 16'(due_results[0].error_code),
					16'(result_bus.error_code));
				void'(due_results.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("srecord_loader_parser regression: fail");
			$finish;
		end
	end

	initial begin
		int unsigned record_no;
		bit          paused_once;
		bit          with_eoi;
		arst_n = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.char_in = '0;
		char_bus.end_of_input = 1'b0;
		parse_phase = srl_pkg::PH_START;
		pending_bytes = '0;
		write_addr = '0;
		byte_sum = '0;
		upper_nibble = '0;
		nibble_held = 1'b0;
		parser_halted = 1'b0;
		hold_req = 1'b0;
		paused_once = 1'b0;
		record_no = 0;
		set_idling(0);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (opening[i]) begin
			send_item(opening[i].eoi, opening[i].ch, opening[i].typed, opening[i].gives,
				opening[i].res);
		end

		while (sent_chars < ITEM_TARGET) begin
			set_idling((record_no / 8) % 4);
			if (!hold_req && sent_chars >= ITEM_TARGET / 3) begin
				hold_req = 1'b1;
			end else if (!paused_once && sent_chars >= 2 * ITEM_TARGET / 3) begin
				paused_once = 1'b1;
				char_bus.valid <= 1'b0;
				do @(negedge clk); while (due_results.size() != 0);
			end
			build_record();
			send_line();
			record_no++;
		end

		with_eoi = build_ending();
		send_line();
		if (with_eoi) send_item(1'b1, 8'($urandom), 1'b0, 1'b0, '0);

		// Once stopped, nothing the parser is given may produce a result.
		set_idling(3);
		repeat (24) send_item(1'($urandom_range(1)), 8'($urandom), 1'b0, 1'b0, '0);

		char_bus.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d characters (%0d parsed) over %0d records in all idling modes.",
			sent_chars, parsed_items, record_no);
		$display("Checked %0d memory writes and %0d start addresses; %s %0d code %0d.",
			writes_seen, starts_seen, "load ended kind", last_kind, last_code);
		if (errors == 0) begin
			$display("srecord_loader_parser regression: pass");
		end else begin
			$display("srecord_loader_parser regression: fail");
		end
		$finish;
	end

endmodule

/* files.f */
sv/srl_pkg.sv
sv/srl_in_if.sv
sv/srl_out_if.sv
sv/srl_step.sv
sv/srecord_loader_parser.sv
test/srecord_loader_parser_test.sv
